>>> src/pidwm_pkg.sv
`default_nettype none

package pidwm_pkg;

	localparam int DATA_W    = 32;
	localparam int ACC_W     = 48;
	localparam int FRAC_W    = 16;
	localparam int MUL_W     = 32;
	localparam int MC_W      = ACC_W + 1;
	localparam int HI_W      = MC_W + 1;
	localparam int PROD_W    = HI_W + MUL_W;
	localparam int TRAP_DIV  = 2000;
	localparam int REM_W     = $clog2(TRAP_DIV);

	localparam int REG_IDX_W = 3;
	localparam int S_DATA_W  = 2 * DATA_W;
	localparam int S_USER_W  = 3;
	localparam int M_DATA_W  = 5 * DATA_W;
	localparam int M_USER_W  = 5;

	localparam logic [REG_IDX_W-1:0] REG_CONTROL_MODE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_P       = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_I       = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_D       = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WINDUP_UPPER = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_WINDUP_LOWER = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_OUTPUT_UPPER = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_OUTPUT_LOWER = 3'd7;

	localparam logic [1:0] WM_NORMAL  = 2'd0;
	localparam logic [1:0] WM_CLAMPED = 2'd1;
	localparam logic [1:0] WM_HELD    = 2'd2;
	localparam logic [1:0] WM_CLEARED = 2'd3;

	localparam logic [2:0] ACT_NORMAL    = 3'd0;
	localparam logic [2:0] ACT_CLAMP_POS = 3'd1;
	localparam logic [2:0] ACT_CLAMP_NEG = 3'd2;
	localparam logic [2:0] ACT_HELD      = 3'd3;
	localparam logic [2:0] ACT_CLEARED   = 3'd4;
	localparam logic [2:0] ACT_INIT      = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_ACT,
		ST_MUL_P,
		ST_FIN_P,
		ST_MUL_D,
		ST_FIN_D,
		ST_MUL_T,
		ST_FIN_T,
		ST_DIV,
		ST_ACC,
		ST_MUL_I,
		ST_FIN_I,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic mul_step;
		logic div_step;
		logic out_load;
	} ctrl_t;

endpackage

`default_nettype wire

>>> src/pid_with_windup_modes_unit.sv
// Channel   Direction  Ports                           Word
// s_*       in         s_tvalid s_tready s_tdata s_tuser  one sample tick
// m_*       out        m_tvalid m_tready m_tdata m_tuser  one controller result
// wr_*      in         wr_en wr_index wr_data          register write, no read-back
//
// One shared shift-add multiplier retires one multiplier bit per cycle over four products
// when the integrator integrates and over three when it holds, clears or is initialized;
// the restoring divider for the trapezoid, used only when it integrates, retires one
// quotient bit per cycle. A new word is accepted only once the last one has been
// loaded into the output register.
// Reset zeroes mode, gains, integrator and stored error; limits reset to full range.
// A finished word waits in the output register; the next word is accepted meanwhile.
`default_nettype none

module pid_with_windup_modes_unit #(
	parameter int PERIOD_MS = 100
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [pidwm_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [pidwm_pkg::DATA_W-1:0]    wr_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// process_value, setpoint
	input  logic [pidwm_pkg::S_DATA_W-1:0]  s_tdata,
	// init_request, hold_positive, hold_negative
	input  logic [pidwm_pkg::S_USER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// control_value, error_value, p_term, i_term, d_term
	output logic [pidwm_pkg::M_DATA_W-1:0]  m_tdata,
	// integrator_action[2:0], output_high_flag, output_low_flag
	output logic [pidwm_pkg::M_USER_W-1:0]  m_tuser
);

	import pidwm_pkg::*;

	localparam int PER_W = $clog2(PERIOD_MS + 1);
	localparam int DVD_W = DATA_W + PER_W;
	localparam int CNT_W = $clog2((DVD_W > MUL_W) ? DVD_W : MUL_W);
	localparam logic [MUL_W-1:0] PERIOD_V = MUL_W'(PERIOD_MS);

	state_t state_q, state_d;
	ctrl_t  ctrl;

	logic        [2:0]        control_mode_q;
	logic signed [DATA_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic signed [DATA_W-1:0] wu_hi_q, wu_lo_q, out_hi_q, out_lo_q;
	logic signed [ACC_W-1:0]  integral_q;
	logic signed [DATA_W-1:0] last_err_q;
	logic                     out_valid_q;

	logic signed [DATA_W-1:0] pv_q, sp_q;
	logic                     init_q, hpos_q, hneg_q;
	logic signed [DATA_W-1:0] err_q, p_q, d_q, i_q;
	logic        [2:0]        action_q;
	logic signed [DATA_W+1:0] cv_q;

	logic signed [MC_W-1:0]   mcand_q;
	logic        [MUL_W-1:0]  mplier_q;
	logic signed [HI_W-1:0]   hi_q;
	logic        [MUL_W-1:0]  lo_q;
	logic        [CNT_W-1:0]  cnt_q;

	logic        [DVD_W-1:0]  dvd_q;
	logic        [REM_W-1:0]  rem_q;
	logic                     neg_q;

	logic        [M_DATA_W-1:0] out_data_q;
	logic        [M_USER_W-1:0] out_user_q;

	function automatic logic signed [DATA_W-1:0] sat_diff(input logic [DATA_W:0] v);
		if (v[DATA_W] == v[DATA_W-1]) begin
			return v[DATA_W-1:0];
		end
		return v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_prod(
		input logic [PROD_W-FRAC_W-1:0] v
	);
		logic [PROD_W-FRAC_W-DATA_W:0] top;
		top = v[PROD_W-FRAC_W-1:DATA_W-1];
		if (&top || ~|top) begin
			return v[DATA_W-1:0];
		end
		return v[PROD_W-FRAC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
			: {1'b0, {(DATA_W-1){1'b1}}};
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic [ACC_W+1:0] v);
		logic [2:0] top;
		top = v[ACC_W+1:ACC_W-1];
		if (&top || ~|top) begin
			return v[ACC_W-1:0];
		end
		return v[ACC_W+1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
	endfunction

	logic signed [DATA_W:0]      diff;
	logic signed [DATA_W:0]      err_step;
	logic signed [DATA_W:0]      trap_in;
	logic signed [DATA_W-1:0]    trap_src;
	logic        [2:0]           action_d;
	logic                        at_pos, at_neg, d_pos, d_neg, beyond, hold;
	logic signed [HI_W-1:0]      mc_ext, addend, mul_sum;
	logic        [PROD_W-1:0]    prod;
	logic signed [DATA_W-1:0]    prod_sat;
	logic        [REM_W:0]       rem_sh;
	logic                        rem_ge;
	logic        [REM_W:0]       rem_nx;
	logic signed [DVD_W:0]       trap_s;
	logic signed [ACC_W+1:0]     acc_sum;
	logic signed [ACC_W-1:0]     acc_sat;
	logic signed [DATA_W+1:0]    pid_sum;
	logic                        flag_hi, flag_lo;
	logic signed [DATA_W-1:0]    out_val;

	always_comb begin
		if (control_mode_q[2]) begin
			diff = (DATA_W+1)'(pv_q) - (DATA_W+1)'(sp_q);
		end else begin
			diff = (DATA_W+1)'(sp_q) - (DATA_W+1)'(pv_q);
		end
		err_step = (DATA_W+1)'(err_q) - (DATA_W+1)'(last_err_q);
	end

	always_comb begin
		at_pos = err_q > wu_hi_q;
		at_neg = err_q < wu_lo_q;
		d_pos  = hpos_q && (err_q > 0);
		d_neg  = hneg_q && (err_q < 0);
		beyond = at_pos || at_neg;
		hold   = d_pos || d_neg;
		if (control_mode_q[1:0] == WM_NORMAL && !hold) begin
			action_d = ACT_NORMAL;
		end else if (control_mode_q[1:0] == WM_CLAMPED && beyond) begin
			action_d = at_pos ? ACT_CLAMP_POS : ACT_CLAMP_NEG;
		end else if (control_mode_q[1:0] == WM_CLEARED && beyond) begin
			action_d = ACT_CLEARED;
		end else if (hold) begin
			action_d = ACT_HELD;
		end else if (control_mode_q[1:0] == WM_HELD && beyond) begin
			action_d = ACT_HELD;
		end else begin
			action_d = ACT_NORMAL;
		end
		if (init_q) begin
			action_d = ACT_INIT;
		end
	end

	always_comb begin
		case (action_q)
			ACT_CLAMP_POS: trap_src = wu_hi_q;
			ACT_CLAMP_NEG: trap_src = wu_lo_q;
			default:       trap_src = err_q;
		endcase
		trap_in = (DATA_W+1)'(trap_src) + (DATA_W+1)'(last_err_q);
	end

	// Signed shift-add product; the top multiplier bit carries negative weight.
	always_comb begin
		mc_ext   = HI_W'(mcand_q);
		addend   = mplier_q[0] ? mc_ext : '0;
		mul_sum  = (cnt_q == '0) ? hi_q - addend : hi_q + addend;
		prod     = {hi_q, lo_q};
		prod_sat = sat_prod(prod[PROD_W-1:FRAC_W]);
	end

	always_comb begin
		rem_sh = {rem_q, dvd_q[DVD_W-1]};
		rem_ge = rem_sh >= (REM_W+1)'(TRAP_DIV);
		rem_nx = rem_ge ? rem_sh - (REM_W+1)'(TRAP_DIV) : rem_sh;
		// A negative dividend was complemented, so complementing the quotient floors it.
		trap_s  = neg_q ? ~{1'b0, dvd_q} : {1'b0, dvd_q};
		acc_sum = (ACC_W+2)'(integral_q) + (ACC_W+2)'(trap_s);
		acc_sat = sat_acc(acc_sum);
	end

	always_comb begin
		pid_sum = (DATA_W+2)'(p_q) + (DATA_W+2)'(i_q) + (DATA_W+2)'(d_q);
		flag_hi = cv_q > (DATA_W+2)'(out_hi_q);
		flag_lo = cv_q < (DATA_W+2)'(out_lo_q);
		if (flag_hi) begin
			out_val = out_hi_q;
		end else if (flag_lo) begin
			out_val = out_lo_q;
		end else begin
			out_val = cv_q[DATA_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_ERR;
			ST_ERR:   state_d = ST_ACT;
			ST_ACT:   state_d = ST_MUL_P;
			ST_MUL_P: if (cnt_q == '0) state_d = ST_FIN_P;
			ST_FIN_P: state_d = ST_MUL_D;
			ST_MUL_D: if (cnt_q == '0) state_d = ST_FIN_D;
			ST_FIN_D: begin
				if (action_q == ACT_INIT || action_q == ACT_CLEARED
						|| action_q == ACT_HELD) begin
					state_d = ST_MUL_I;
				end else begin
					state_d = ST_MUL_T;
				end
			end
			ST_MUL_T: if (cnt_q == '0) state_d = ST_FIN_T;
			ST_FIN_T: state_d = ST_DIV;
			ST_DIV:   if (cnt_q == '0) state_d = ST_ACC;
			ST_ACC:   state_d = ST_MUL_I;
			ST_MUL_I: if (cnt_q == '0) state_d = ST_FIN_I;
			ST_FIN_I: state_d = ST_SUM;
			ST_SUM:   state_d = ST_OUT;
			ST_OUT:   if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE: ctrl.in_ready = 1'b1;
			ST_MUL_P, ST_MUL_D, ST_MUL_T, ST_MUL_I: ctrl.mul_step = 1'b1;
			ST_DIV:  ctrl.div_step = 1'b1;
			ST_OUT:  ctrl.out_load = !out_valid_q || m_tready;
			default: ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			control_mode_q <= '0;
			gain_p_q       <= '0;
			gain_i_q       <= '0;
			gain_d_q       <= '0;
			wu_hi_q        <= {1'b0, {(DATA_W-1){1'b1}}};
			wu_lo_q        <= {1'b1, {(DATA_W-1){1'b0}}};
			out_hi_q       <= {1'b0, {(DATA_W-1){1'b1}}};
			out_lo_q       <= {1'b1, {(DATA_W-1){1'b0}}};
			integral_q     <= '0;
			last_err_q     <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				case (wr_index)
					REG_CONTROL_MODE: control_mode_q <= wr_data[2:0];
					REG_GAIN_P:       gain_p_q       <= wr_data;
					REG_GAIN_I:       gain_i_q       <= wr_data;
					REG_GAIN_D:       gain_d_q       <= wr_data;
					REG_WINDUP_UPPER: wu_hi_q        <= wr_data;
					REG_WINDUP_LOWER: wu_lo_q        <= wr_data;
					REG_OUTPUT_UPPER: out_hi_q       <= wr_data;
					REG_OUTPUT_LOWER: out_lo_q       <= wr_data;
					default: ;
				endcase
			end
			if (state_q == ST_FIN_D
					&& (action_q == ACT_INIT || action_q == ACT_CLEARED)) begin
				integral_q <= '0;
			end
			if (state_q == ST_ACC) begin
				integral_q <= acc_sat;
			end
			if (state_q == ST_SUM) begin
				last_err_q <= err_q;
			end
			if (ctrl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.in_ready && s_tvalid) begin
			pv_q   <= s_tdata[DATA_W-1:0];
			sp_q   <= s_tdata[2*DATA_W-1:DATA_W];
			init_q <= s_tuser[0];
			hpos_q <= s_tuser[1];
			hneg_q <= s_tuser[2];
		end
		if (ctrl.mul_step) begin
			hi_q     <= {mul_sum[HI_W-1], mul_sum[HI_W-1:1]};
			lo_q     <= {mul_sum[0], lo_q[MUL_W-1:1]};
			mplier_q <= {1'b0, mplier_q[MUL_W-1:1]};
			cnt_q    <= cnt_q - 1'b1;
		end
		if (ctrl.div_step) begin
			rem_q <= rem_nx[REM_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], rem_ge};
			cnt_q <= cnt_q - 1'b1;
		end
		if (ctrl.out_load) begin
			out_data_q <= {d_q, i_q, p_q, err_q, out_val};
			out_user_q <= {flag_lo, flag_hi, action_q};
		end
		case (state_q)
			ST_ERR: err_q <= sat_diff(diff);
			ST_ACT: begin
				action_q <= action_d;
				mcand_q  <= MC_W'(err_q);
				mplier_q <= gain_p_q;
				hi_q     <= '0;
				cnt_q    <= CNT_W'(MUL_W - 1);
			end
			ST_FIN_P: begin
				p_q      <= prod_sat;
				mcand_q  <= MC_W'(err_step);
				mplier_q <= gain_d_q;
				hi_q     <= '0;
				cnt_q    <= CNT_W'(MUL_W - 1);
			end
			ST_FIN_D: begin
				d_q   <= prod_sat;
				hi_q  <= '0;
				cnt_q <= CNT_W'(MUL_W - 1);
				if (action_q == ACT_INIT || action_q == ACT_CLEARED) begin
					mcand_q  <= '0;
					mplier_q <= gain_i_q;
				end else if (action_q == ACT_HELD) begin
					mcand_q  <= MC_W'(integral_q);
					mplier_q <= gain_i_q;
				end else begin
					mcand_q  <= MC_W'(trap_in);
					mplier_q <= PERIOD_V;
				end
			end
			ST_FIN_T: begin
				neg_q <= prod[DVD_W];
				dvd_q <= prod[DVD_W] ? ~prod[DVD_W-1:0] : prod[DVD_W-1:0];
				rem_q <= '0;
				cnt_q <= CNT_W'(DVD_W - 1);
			end
			ST_ACC: begin
				mcand_q  <= MC_W'(acc_sat);
				mplier_q <= gain_i_q;
				hi_q     <= '0;
				cnt_q    <= CNT_W'(MUL_W - 1);
			end
			ST_FIN_I: i_q <= prod_sat;
			ST_SUM:   cv_q <= init_q ? '0 : pid_sum;
			default: ;
		endcase
	end

	assign s_tready = ctrl.in_ready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_ERR))
		else $error("Accepted word did not start the error step.");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < REM_W'(TRAP_DIV)))
		else $error("Divider remainder reached the divisor.");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_OUT))
		else $error("Output became valid outside the output step.");

	a_zero_integral: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN_D && (action_q == ACT_INIT || action_q == ACT_CLEARED))
		|=> (integral_q == '0))
		else $error("Integrator not cleared on init or clear.");

	a_zero_i_term: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser[2:0] == ACT_INIT || m_tuser[2:0] == ACT_CLEARED))
		|-> (m_tdata[4*DATA_W-1:3*DATA_W] == '0))
		else $error("Nonzero I term after the integrator was cleared.");

endmodule

`default_nettype wire
